### rtl/plal_pkg.sv
`timescale 1ns / 1ps
package plal_pkg;

  localparam int MaxNodes = 256;
  localparam int AddrW    = $clog2(MaxNodes);
  localparam int CountW   = AddrW + 1;
  localparam int SearchSteps = CountW;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] node_z;
    logic [31:0]        node_arc;
    logic [16:0]        along;
  } req_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [1:0]         status;
  } rsp_t;

  // One node row as stored in the node memory.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } node_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TOTAL_RD,
    S_TOTAL_WAIT,
    S_MUL,
    S_SRCH_RD,
    S_SRCH_WAIT,
    S_LO_RD,
    S_HI_RD,
    S_HI_WAIT,
    S_DIV,
    S_LERP_X,
    S_LERP_Y,
    S_LERP_Z,
    S_OUT
  } state_e;

endpackage

### rtl/plal_ram.sv
`timescale 1ns / 1ps
module plal_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/plal_div.sv
`timescale 1ns / 1ps
module plal_div
  import plal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [16:0] quo_o
);

  // Restoring divider, one quotient bit per cycle. The quotient is
  // saturated to 65536, so bits above the low 17 only need to be seen as overflow.
  logic [47:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [47:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], num_q[47]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[46:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = (quo_q > 48'd65536) ? 17'd65536 : quo_q[16:0];

endmodule

### rtl/plal_ctrl.sv
`timescale 1ns / 1ps
module plal_ctrl
  import plal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output rsp_t        rsp_o,
  // Memory ports.
  output logic             we_o,
  output logic [AddrW-1:0] waddr_o,
  output node_t            wnode_o,
  output logic [31:0]      warc_o,
  output logic [AddrW-1:0] node_raddr_o,
  input  node_t            node_rdata_i,
  output logic [AddrW-1:0] arc_raddr_o,
  input  logic [31:0]      arc_rdata_i,
  // Divider.
  output logic        div_start_o,
  output logic [47:0] div_num_o,
  output logic [31:0] div_den_o,
  input  logic        div_done_i,
  input  logic [16:0] div_quo_i
);

  state_e state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [16:0]       f_q, f_d;
  logic [31:0]       total_q, total_d;
  logic [31:0]       s_q, s_d;
  logic [CountW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CountW-1:0] mid;
  logic [31:0]       arc_lo_q, arc_lo_d;
  logic [16:0]       t_q, t_d;
  node_t             a_q, a_d;
  rsp_t              rsp_q, rsp_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic [48:0]       prod_full;
  logic signed [32:0] diff;
  logic signed [50:0] lprod;
  logic signed [50:0] lstep;
  logic [31:0]        lres;
  logic [CountW-1:0]  hi_idx;

  assign mid = (lo_q + hi_q) >> 1;
  assign prod_full = {32'd0, f_q} * {17'd0, total_q};

  // Selected coordinate pair for the current interpolation step.
  logic [31:0] ca, cb;
  always_comb begin
    case (state_q)
      S_LERP_X: begin ca = a_q.x; cb = node_rdata_i.x; end
      S_LERP_Y: begin ca = a_q.y; cb = node_rdata_i.y; end
      default:  begin ca = a_q.z; cb = node_rdata_i.z; end
    endcase
  end

  // Floor of d*t/65536, then added to the lower node.
  always_comb begin
    diff  = $signed({cb[31], cb}) - $signed({ca[31], ca});
    lprod = 51'(diff) * $signed({34'd0, t_q});
    lstep = lprod >>> 16;
    lres  = ca + lstep[31:0];
  end

  always_comb begin
    hi_idx = (lo_q > count_q - CountW'(1)) ? count_q - CountW'(1) : lo_q;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    f_d         = f_q;
    total_d     = total_q;
    s_d         = s_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    arc_lo_d    = arc_lo_q;
    t_d         = t_q;
    a_d         = a_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    we_o        = 1'b0;
    waddr_o     = count_q[AddrW-1:0];
    wnode_o     = '{x: req_i.node_x, y: req_i.node_y, z: req_i.node_z};
    warc_o      = req_i.node_arc;
    node_raddr_o = '0;
    arc_raddr_o  = '0;
    div_start_o  = 1'b0;
    div_num_o    = '0;
    div_den_o    = '0;
    req_ready_o  = 1'b0;

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        req_ready_o = !rsp_valid_q || rsp_ready_i;
        if (req_valid_i && req_ready_o) begin
          rsp_d = '0;
          case (mode_e'(req_i.mode))
            MODE_CLEAR: begin
              count_d = '0;
              rsp_valid_d = 1'b1;
            end
            MODE_APPEND: begin
              if (count_q < CountW'(MaxNodes)) begin
                we_o    = 1'b1;
                count_d = count_q + CountW'(1);
              end else begin
                rsp_d.status = ST_FULL;
              end
              rsp_valid_d = 1'b1;
            end
            MODE_QUERY: begin
              if (count_q == '0) begin
                rsp_d.status = ST_EMPTY;
                rsp_valid_d  = 1'b1;
              end else begin
                f_d     = (req_i.along > 17'd65536) ? 17'd65536 : req_i.along;
                state_d = S_TOTAL_RD;
              end
            end
            default: rsp_valid_d = 1'b1;
          endcase
        end
      end
      S_TOTAL_RD: begin
        arc_raddr_o  = AddrW'(count_q - CountW'(1));
        node_raddr_o = '0;
        state_d      = S_TOTAL_WAIT;
      end
      S_TOTAL_WAIT: begin
        total_d = arc_rdata_i;
        if (count_q == CountW'(1) || arc_rdata_i == '0) begin
          rsp_d.point_x = node_rdata_i.x;
          rsp_d.point_y = node_rdata_i.y;
          rsp_d.point_z = node_rdata_i.z;
          state_d = S_OUT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        s_d     = prod_full[47:16];
        lo_d    = '0;
        hi_d    = count_q;
        state_d = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (lo_q < hi_q) begin
          arc_raddr_o = mid[AddrW-1:0];
          state_d     = S_SRCH_WAIT;
        end else begin
          state_d = S_LO_RD;
        end
      end
      S_SRCH_WAIT: begin
        if (arc_rdata_i <= s_q) lo_d = mid + CountW'(1);
        else hi_d = mid;
        state_d = S_SRCH_RD;
      end
      S_LO_RD: begin
        // Fix hi, derive lo, and read the lower entry.
        hi_d = hi_idx;
        lo_d = (hi_idx != '0) ? hi_idx - CountW'(1) : '0;
        arc_raddr_o  = AddrW'(lo_d);
        node_raddr_o = AddrW'(lo_d);
        state_d = S_HI_RD;
      end
      S_HI_RD: begin
        arc_lo_d     = arc_rdata_i;
        a_d          = node_rdata_i;
        arc_raddr_o  = AddrW'(hi_q);
        node_raddr_o = AddrW'(hi_q);
        state_d      = S_HI_WAIT;
      end
      S_HI_WAIT: begin
        node_raddr_o = AddrW'(hi_q);
        arc_raddr_o  = AddrW'(hi_q);
        if (arc_rdata_i > arc_lo_q) begin
          div_start_o = 1'b1;
          div_num_o   = (s_q > arc_lo_q) ? {s_q - arc_lo_q, 16'd0} : '0;
          div_den_o   = arc_rdata_i - arc_lo_q;
          state_d     = S_DIV;
        end else begin
          t_d     = '0;
          state_d = S_LERP_X;
        end
      end
      S_DIV: begin
        node_raddr_o = AddrW'(hi_q);
        if (div_done_i) begin
          t_d     = div_quo_i;
          state_d = S_LERP_X;
        end
      end
      S_LERP_X: begin
        node_raddr_o  = AddrW'(hi_q);
        rsp_d.point_x = lres;
        state_d       = S_LERP_Y;
      end
      S_LERP_Y: begin
        node_raddr_o  = AddrW'(hi_q);
        rsp_d.point_y = lres;
        state_d       = S_LERP_Z;
      end
      S_LERP_Z: begin
        node_raddr_o  = AddrW'(hi_q);
        rsp_d.point_z = lres;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q      <= f_d;
    total_q  <= total_d;
    s_q      <= s_d;
    arc_lo_q <= arc_lo_d;
    t_q      <= t_d;
    a_q      <= a_d;
    rsp_q    <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### rtl/polyline_arc_length_point_lookup_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Payload
// req     | in        | req_valid_i/req_ready_o | req_i  (req_t)
// rsp     | out       | rsp_valid_o/rsp_ready_i | rsp_o  (rsp_t)
//
// Clear, append and unused requests give a response on the cycle after acceptance.
// A query runs k binary search steps (at most 9), each a read state and a wait
// state on the arc memory, then fixed reads, a wait on the bit-serial divider
// and three interpolation states. A zero span skips the divide; a single node
// or zero total goes from the total read straight to the response.
// Reset clears the node count and control state; table memories need no clearing.
// A stalled response holds the block; a new request is taken as it leaves.
module polyline_arc_length_point_lookup_unit
  import plal_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  logic             we;
  logic [AddrW-1:0] waddr, node_raddr, arc_raddr;
  node_t            wnode, node_rdata;
  logic [31:0]      warc, arc_rdata;
  logic             div_start, div_done;
  logic [47:0]      div_num;
  logic [31:0]      div_den;
  logic [16:0]      div_quo;

  plal_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o,
    .we_o(we), .waddr_o(waddr), .wnode_o(wnode), .warc_o(warc),
    .node_raddr_o(node_raddr), .node_rdata_i(node_rdata),
    .arc_raddr_o(arc_raddr), .arc_rdata_i(arc_rdata),
    .div_start_o(div_start), .div_num_o(div_num), .div_den_o(div_den),
    .div_done_i(div_done), .div_quo_i(div_quo)
  );

  plal_ram #(.Width($bits(node_t)), .Depth(MaxNodes)) u_node_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wnode),
    .raddr_i(node_raddr), .rdata_o(node_rdata)
  );

  plal_ram #(.Width(32), .Depth(MaxNodes)) u_arc_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(warc),
    .raddr_i(arc_raddr), .rdata_o(arc_rdata)
  );

  plal_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

endmodule

### rtl/plal_checker.sv
`timescale 1ns / 1ps
module plal_checker
  import plal_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_o,
  input req_t req_i,
  input logic rsp_valid_o,
  input logic rsp_ready_i,
  input rsp_t rsp_o
);

  // A stalled response keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  // Status never carries the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.status != 2'd3)
    else $error("bad status code");

  // Non-ok statuses come with a zero point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != ST_OK |->
      rsp_o.point_x == '0 && rsp_o.point_y == '0 && rsp_o.point_z == '0)
    else $error("error response with nonzero point");

  // A request accepted with a stalled response outstanding is impossible.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |-> !rsp_valid_o || rsp_ready_i)
    else $error("request taken over a held response");

endmodule

bind polyline_arc_length_point_lookup_unit plal_checker u_plal_checker (.*);
